>>> sv/sbpf_pkg.sv
// Shared types and constants for the servo bus packet framer.
// No dependencies; the stage modules and the top level import this package.
`default_nettype none
package sbpf_pkg;

  localparam int MaxBytes = 17;
  localparam int IdxW     = $clog2(MaxBytes);

  // Command codes
  typedef enum logic [1:0] {
    CMD_GOAL_WRITE = 2'd0,
    CMD_ACTION     = 2'd1,
    CMD_ANGLE_READ = 2'd2,
    CMD_TORQUE_EN  = 2'd3
  } cmd_e_t;

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] BROADCAST_ID    = 8'd254;
  localparam logic [7:0] INSTR_READ      = 8'd2;
  localparam logic [7:0] INSTR_WRITE     = 8'd3;
  localparam logic [7:0] INSTR_REG_WRITE = 8'd4;
  localparam logic [7:0] INSTR_ACTION    = 8'd5;
  localparam logic [7:0] ADDR_GOAL_BLOCK = 8'd26;
  localparam logic [7:0] ADDR_POSITION   = 8'h24;
  localparam logic [7:0] ADDR_TORQUE_EN  = 8'h18;
  localparam logic [7:0] GOAL_LENGTH     = 8'd13;
  localparam logic [7:0] SHORT_LENGTH    = 8'd4;
  localparam logic [7:0] ACTION_LENGTH   = 8'd2;
  localparam logic [7:0] READ_COUNT      = 8'd2;

  // Index of the checksum byte for each packet kind
  localparam logic [IdxW-1:0] LAST_GOAL   = IdxW'(16);
  localparam logic [IdxW-1:0] LAST_ACTION = IdxW'(5);
  localparam logic [IdxW-1:0] LAST_SHORT  = IdxW'(7);

  // Packet image: bytes in send order, unused bytes zero
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
  } pkt_t;

endpackage
`default_nettype wire

>>> sv/sbpf_if.sv
// Channel interfaces: command items in, packet bytes out.
// Plain valid/ready handshake; no package dependency.
`default_nettype none
interface sbpf_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] servo_id;
  logic [7:0] cw_margin;
  logic [7:0] ccw_margin;
  logic [7:0] cw_slope;
  logic [7:0] ccw_slope;
  logic [9:0] goal_position;
  logic [9:0] moving_speed;
  logic [9:0] torque_limit;
  logic [7:0] torque_on;

  modport source (output valid, command, servo_id, cw_margin, ccw_margin, cw_slope,
                  ccw_slope, goal_position, moving_speed, torque_limit, torque_on,
                  input ready);
  modport sink (input valid, command, servo_id, cw_margin, ccw_margin, cw_slope,
                ccw_slope, goal_position, moving_speed, torque_limit, torque_on,
                output ready);
endinterface

interface sbpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface
`default_nettype wire

>>> sv/sbpf_build.sv
// Stage 1: assembles the packet image (checksum slot still zero).
// Depends on sbpf_pkg and sbpf_cmd_if.
`default_nettype none
module sbpf_build (
  input  wire logic          clk,
  input  wire logic          rst,
  sbpf_cmd_if.sink           cmd,
  output logic               valid,
  output sbpf_pkg::pkt_t     pkt,
  input  wire logic          ready
);
  import sbpf_pkg::*;

  pkt_t pkt_next;

  assign cmd.ready = !valid || ready;

  always_comb begin
    pkt_next = '0;
    pkt_next.bytes[0] = SYNC_BYTE;
    pkt_next.bytes[1] = SYNC_BYTE;
    case (cmd.command)
      CMD_GOAL_WRITE: begin
        pkt_next.bytes[2]  = cmd.servo_id;
        pkt_next.bytes[3]  = GOAL_LENGTH;
        pkt_next.bytes[4]  = INSTR_REG_WRITE;
        pkt_next.bytes[5]  = ADDR_GOAL_BLOCK;
        pkt_next.bytes[6]  = cmd.cw_margin;
        pkt_next.bytes[7]  = cmd.ccw_margin;
        pkt_next.bytes[8]  = cmd.cw_slope;
        pkt_next.bytes[9]  = cmd.ccw_slope;
        pkt_next.bytes[10] = cmd.goal_position[7:0];
        pkt_next.bytes[11] = {6'd0, cmd.goal_position[9:8]};
        pkt_next.bytes[12] = cmd.moving_speed[7:0];
        pkt_next.bytes[13] = {6'd0, cmd.moving_speed[9:8]};
        pkt_next.bytes[14] = cmd.torque_limit[7:0];
        pkt_next.bytes[15] = {6'd0, cmd.torque_limit[9:8]};
        pkt_next.last_idx  = LAST_GOAL;
      end
      CMD_ACTION: begin
        pkt_next.bytes[2] = BROADCAST_ID;
        pkt_next.bytes[3] = ACTION_LENGTH;
        pkt_next.bytes[4] = INSTR_ACTION;
        pkt_next.last_idx = LAST_ACTION;
      end
      CMD_ANGLE_READ: begin
        pkt_next.bytes[2] = cmd.servo_id;
        pkt_next.bytes[3] = SHORT_LENGTH;
        pkt_next.bytes[4] = INSTR_READ;
        pkt_next.bytes[5] = ADDR_POSITION;
        pkt_next.bytes[6] = READ_COUNT;
        pkt_next.last_idx = LAST_SHORT;
      end
      CMD_TORQUE_EN: begin
        pkt_next.bytes[2] = cmd.servo_id;
        pkt_next.bytes[3] = SHORT_LENGTH;
        pkt_next.bytes[4] = INSTR_WRITE;
        pkt_next.bytes[5] = ADDR_TORQUE_EN;
        pkt_next.bytes[6] = cmd.torque_on;
        pkt_next.last_idx = LAST_SHORT;
      end
      default: begin
        pkt_next.last_idx = LAST_SHORT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready) begin
      pkt <= pkt_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/sbpf_sum.sv
// Stage 2: checksum over id..last parameter, placed at the last byte.
// Depends on sbpf_pkg.
`default_nettype none
module sbpf_sum (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire sbpf_pkg::pkt_t  in_pkt,
  output logic                 in_ready,
  output logic                 valid,
  output sbpf_pkg::pkt_t       pkt,
  input  wire logic            ready
);
  import sbpf_pkg::*;

  logic [6:0][7:0] pair;
  logic [7:0]      total;
  pkt_t            pkt_next;

  assign in_ready = !valid || ready;

  // Unused bytes are zero, so summing bytes 2..15 is right for every kind
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      pair[i] = in_pkt.bytes[2 + 2*i] + in_pkt.bytes[3 + 2*i];
    end
    total = ((pair[0] + pair[1]) + (pair[2] + pair[3])) +
            ((pair[4] + pair[5]) + pair[6]);
  end

  always_comb begin
    pkt_next = in_pkt;
    for (int k = 0; k < MaxBytes; k++) begin
      if (IdxW'(k) == in_pkt.last_idx) begin
        pkt_next.bytes[k] = ~total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pkt <= pkt_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/sbpf_ser.sv
// Stage 3: holds one finished packet and sends it a byte per cycle while tx is ready.
// Depends on sbpf_pkg and sbpf_byte_if.
`default_nettype none
module sbpf_ser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire sbpf_pkg::pkt_t  in_pkt,
  output logic                 in_ready,
  sbpf_byte_if.source          tx
);
  import sbpf_pkg::*;

  logic            valid;
  pkt_t            cur;
  logic [IdxW-1:0] idx;
  logic            at_last;

  assign at_last      = (idx == cur.last_idx);
  assign tx.valid     = valid;
  assign tx.tx_byte   = cur.bytes[idx];
  assign tx.last_byte = at_last;
  // Next packet loads in the cycle the checksum byte leaves
  assign in_ready     = !valid || (tx.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (in_ready) begin
      valid <= in_valid;
      idx   <= '0;
    end else if (tx.ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cur <= in_pkt;
    end
  end

endmodule
`default_nettype wire

>>> sv/servo_bus_packet_framer_top.sv
// Top level of the servo bus packet framer: build, checksum, serialize.
// Depends on sbpf_pkg, sbpf_if.sv and the three stage modules.
`default_nettype none
//
// Channel | Dir | Item                         | Handshake
// --------+-----+------------------------------+-------------------------
// cmd     | in  | one command and its fields   | valid/ready, sink
// tx      | out | one packet byte + last flag  | valid/ready, source
//
// Pipeline: three register stages (build, checksum, serializer). A command
// passes the build and checksum registers before its first byte reaches tx;
// the packet then leaves at one byte per cycle while tx is ready, 17, 6 or 8
// bytes by command. The serializer sets the sustained rate: it loads the next
// packet as the checksum byte leaves, so packets go back to back with no gap.
// Reset: rst clears the stage valid bits; payload registers are not reset.
// Stalls: each stage holds while full and blocked downstream; a stall
// on tx freezes the byte index, so nothing is dropped or repeated.
module servo_bus_packet_framer_top (
  input  wire logic clk,
  input  wire logic rst,
  sbpf_cmd_if.sink   cmd,
  sbpf_byte_if.source tx
);
  import sbpf_pkg::*;

  logic s1_valid;
  logic s1_ready;
  pkt_t s1_pkt;
  logic s2_valid;
  logic s2_ready;
  pkt_t s2_pkt;

  // Stage 1: packet image from the command fields
  sbpf_build u_build (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .valid (s1_valid),
    .pkt   (s1_pkt),
    .ready (s1_ready)
  );

  // Stage 2: checksum tree, inserted at the packet's last byte
  sbpf_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_pkt   (s1_pkt),
    .in_ready (s1_ready),
    .valid    (s2_valid),
    .pkt      (s2_pkt),
    .ready    (s2_ready)
  );

  // Stage 3: byte serializer; its packet register is the output register
  sbpf_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_pkt   (s2_pkt),
    .in_ready (s2_ready),
    .tx       (tx)
  );

  // A packet never breaks off: after a middle byte goes, another follows
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && !tx.last_byte) |=> tx.valid)
    else $error("packet interrupted mid-stream");

  // Every packet that follows another opens with a sync byte
  a_sync_first: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.last_byte) |=> (!tx.valid || tx.tx_byte == SYNC_BYTE))
    else $error("packet does not open with sync byte");

  // No packet that follows another is shorter than two bytes
  a_no_double_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.last_byte) |=> !(tx.valid && tx.last_byte))
    else $error("checksum byte repeated");

  // A full serializer that is not finishing a packet takes no new one
  a_hold_upstream: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !(tx.ready && tx.last_byte)) |-> !s2_ready)
    else $error("serializer accepted a packet while busy");

endmodule
`default_nettype wire
